@@ hdl/gss_pkg.sv @@
// Gauss-Seidel solver package: sizes, opcodes, status codes and the sequencer state type.
// Used by every module of the solver; depends on nothing.
`default_nettype none
package gss_pkg;
   localparam int MAX_SIZE = 16;
   localparam int IDX_W    = $clog2(MAX_SIZE);
   localparam int MAT_W    = 2 * IDX_W;
   localparam int SIZE_W   = 5;
   localparam int TOL_W    = 31;
   localparam int LIM_W    = 16;

   localparam logic [1:0] OP_LOAD_A = 2'd0;
   localparam logic [1:0] OP_LOAD_B = 2'd1;
   localparam logic [1:0] OP_START  = 2'd2;
   localparam logic [1:0] OP_NONE   = 2'd3;

   localparam logic [1:0] CSR_SIZE  = 2'd0;
   localparam logic [1:0] CSR_TOL   = 2'd1;
   localparam logic [1:0] CSR_LIMIT = 2'd2;

   localparam logic [1:0] ST_CONVERGED = 2'd0;
   localparam logic [1:0] ST_LIMIT     = 2'd1;
   localparam logic [1:0] ST_ZERO_DIAG = 2'd2;

   typedef enum logic [3:0] {
      S_IDLE, S_DCHK_RD, S_DCHK, S_ROW_RD, S_ROW_INIT, S_MAC_RD, S_MUL, S_SUB,
      S_DIV_GO, S_DIV_WAIT, S_CHECK, S_EMIT
   } state_type;

   typedef struct packed {
      logic start;
      logic busy;
      logic done;
   } div_ctl_type;
endpackage
`default_nettype wire

@@ hdl/gss_div.sv @@
// Gauss-Seidel solver divider: 64 by 32 bit signed restoring division, one quotient bit a cycle,
// quotient truncated toward zero and saturated to 32 bits. Depends on gss_pkg.
`default_nettype none
module gss_div (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               start,
   input  wire logic signed [63:0] dividend,
   input  wire logic signed [31:0] divisor,
   output gss_pkg::div_ctl_type    ctl,
   output logic signed [31:0]      quotient
);
   logic [63:0] rem_ff, rem_in;
   logic [63:0] quo_ff, quo_in;
   logic [31:0] den_ff, den_in;
   logic [6:0]  cnt_ff, cnt_in;
   logic        neg_ff, neg_in;
   logic        busy_ff, busy_in;
   logic        done_ff, done_in;
   logic [64:0] trial;
   logic [63:0] shifted;

   always_comb begin
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      den_in  = den_ff;
      cnt_in  = cnt_ff;
      neg_in  = neg_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      shifted = {rem_ff[62:0], quo_ff[63]};
      trial   = {1'b0, shifted} - {33'd0, den_ff};
      if (start) begin
         rem_in  = '0;
         quo_in  = dividend[63] ? 64'd0 - dividend : dividend;
         den_in  = divisor[31] ? 32'd0 - divisor : divisor;
         neg_in  = dividend[63] ^ divisor[31];
         cnt_in  = 7'd0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (!trial[64]) begin
            rem_in = trial[63:0];
         end else begin
            rem_in = shifted;
         end
         quo_in = {quo_ff[62:0], ~trial[64]};
         cnt_in = cnt_ff + 7'd1;
         if (cnt_ff == 7'd63) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      den_ff <= den_in;
      neg_ff <= neg_in;
      cnt_ff <= cnt_in;
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   always_comb begin
      ctl.start = start;
      ctl.busy  = busy_ff;
      ctl.done  = done_ff;
      if (!neg_ff) begin
         quotient = (quo_ff > 64'h7fff_ffff) ? 32'sh7fff_ffff : quo_ff[31:0];
      end else if (quo_ff >= 64'h8000_0000) begin
         quotient = 32'sh8000_0000;
      end else begin
         quotient = 32'd0 - quo_ff[31:0];
      end
   end
endmodule
`default_nettype wire

@@ hdl/gauss_seidel_solver_unit.sv @@
// Gauss-Seidel solver top level: stores, sequencer, shared multiply-accumulate and divider.
// Depends on gss_pkg and gss_div.
//
// channel  direction  handshake          payload
// req      in         start & !busy      req_opcode, req_row, req_column, req_value
// rsp      out        rsp_valid strobe   rsp_index, rsp_solution, rsp_status, rsp_last
// csr      in         csr_write_enable   csr_index, csr_data
//
// Load items are written when accepted. A solve first checks every diagonal entry, then per sweep
// works through n rows, paced by the single multiplier and the bit-serial divider, then checks
// n unknowns for convergence, then emits n results. Reset is synchronous and clears the control
// state and iterates; the stores hold garbage until written. Results cannot be stalled: one
// result per cycle while emitting.
`default_nettype none
module gauss_seidel_solver_unit (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               start,
   output logic                    busy,
   input  wire logic [1:0]         req_opcode,
   input  wire logic [3:0]         req_row,
   input  wire logic [3:0]         req_column,
   input  wire logic signed [31:0] req_value,
   output logic                    rsp_valid,
   output logic [3:0]              rsp_index,
   output logic signed [31:0]      rsp_solution,
   output logic [1:0]              rsp_status,
   output logic                    rsp_last,
   input  wire logic               csr_write_enable,
   input  wire logic [1:0]         csr_index,
   input  wire logic [30:0]        csr_data
);
   localparam int IW = gss_pkg::IDX_W;

   logic [31:0] mat_mem [gss_pkg::MAX_SIZE * gss_pkg::MAX_SIZE];
   logic [31:0] rhs_mem [gss_pkg::MAX_SIZE];
   logic signed [31:0] prev_ff [gss_pkg::MAX_SIZE];
   logic signed [31:0] cur_ff  [gss_pkg::MAX_SIZE];

   logic [gss_pkg::SIZE_W-1:0] size_ff;
   logic [gss_pkg::TOL_W-1:0]  tol_ff;
   logic [gss_pkg::LIM_W-1:0]  lim_ff;

   gss_pkg::state_type state_ff, state_in;
   logic [IW-1:0] i_ff, i_in, j_ff, j_in;
   logic [IW-1:0] last_ff;
   logic [gss_pkg::LIM_W-1:0] sweep_ff, sweep_in;
   logic          zd_ff, zd_in, conv_ff, conv_in;
   logic [1:0]    stat_ff, stat_in;
   logic signed [63:0] acc_ff, acc_in;
   logic signed [63:0] prod_ff;
   logic [31:0]   a_rd_ff, b_rd_ff;
   logic signed [31:0] x_ff;
   logic [IW-1:0] rd_row, rd_col;
   logic          div_start;
   gss_pkg::div_ctl_type div_ctl;
   logic signed [31:0] div_q;
   logic signed [63:0] diff;
   logic [63:0] adiff;
   logic signed [63:0] sub_r;
   logic        accept;
   logic [IW-1:0] nm1;

   assign accept = start && (state_ff == gss_pkg::S_IDLE);
   assign busy   = (state_ff != gss_pkg::S_IDLE);

   always_comb begin
      if (size_ff == '0) begin
         nm1 = '0;
      end else if (size_ff > gss_pkg::SIZE_W'(gss_pkg::MAX_SIZE)) begin
         nm1 = IW'(gss_pkg::MAX_SIZE - 1);
      end else begin
         nm1 = IW'(size_ff - 5'd1);
      end
   end

   // memory reads, registered
   always_comb begin
      rd_row = i_ff;
      rd_col = j_ff;
      if (state_ff == gss_pkg::S_DCHK_RD || state_ff == gss_pkg::S_DCHK) begin
         rd_col = i_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (accept && req_opcode == gss_pkg::OP_LOAD_A) begin
         mat_mem[{req_row, req_column}] <= req_value;
      end
      if (accept && req_opcode == gss_pkg::OP_LOAD_B) begin
         rhs_mem[req_row] <= req_value;
      end
      a_rd_ff <= mat_mem[{rd_row, rd_col}];
      b_rd_ff <= rhs_mem[rd_row];
      x_ff    <= (j_ff < i_ff) ? cur_ff[j_ff] : prev_ff[j_ff];
      prod_ff <= 64'(signed'(a_rd_ff)) * 64'(x_ff);
      acc_ff  <= acc_in;
   end

   // saturating subtract of the product
   always_comb begin
      sub_r = acc_ff - prod_ff;
      if (acc_ff[63] != prod_ff[63] && sub_r[63] != acc_ff[63]) begin
         sub_r = acc_ff[63] ? 64'sh8000_0000_0000_0000 : 64'sh7fff_ffff_ffff_ffff;
      end
      diff  = 64'(cur_ff[i_ff]) - 64'(prev_ff[i_ff]);
      adiff = diff[63] ? 64'd0 - diff : diff;
   end

   always_comb begin
      state_in  = state_ff;
      i_in      = i_ff;
      j_in      = j_ff;
      sweep_in  = sweep_ff;
      zd_in     = zd_ff;
      conv_in   = conv_ff;
      stat_in   = stat_ff;
      acc_in    = acc_ff;
      div_start = 1'b0;
      case (state_ff)
         gss_pkg::S_IDLE: begin
            if (accept && req_opcode == gss_pkg::OP_START) begin
               i_in     = '0;
               j_in     = '0;
               sweep_in = '0;
               zd_in    = 1'b0;
               state_in = gss_pkg::S_DCHK_RD;
            end
         end
         gss_pkg::S_DCHK_RD: state_in = gss_pkg::S_DCHK;
         gss_pkg::S_DCHK: begin
            if (a_rd_ff == '0) begin
               zd_in = 1'b1;
            end
            if (i_ff == nm1) begin
               i_in = '0;
               j_in = '0;
               if (zd_in) begin
                  stat_in  = gss_pkg::ST_ZERO_DIAG;
                  state_in = gss_pkg::S_EMIT;
               end else begin
                  state_in = gss_pkg::S_ROW_RD;
               end
            end else begin
               i_in     = i_ff + 1'b1;
               state_in = gss_pkg::S_DCHK_RD;
            end
         end
         gss_pkg::S_ROW_RD: state_in = gss_pkg::S_ROW_INIT;
         gss_pkg::S_ROW_INIT: begin
            acc_in = {{16{b_rd_ff[31]}}, b_rd_ff, 16'd0};
            j_in   = (i_ff == '0) ? IW'(1) : '0;
            if (nm1 == '0) begin
               state_in = gss_pkg::S_DIV_GO;
            end else begin
               state_in = gss_pkg::S_MAC_RD;
            end
         end
         gss_pkg::S_MAC_RD: state_in = gss_pkg::S_MUL;
         gss_pkg::S_MUL:    state_in = gss_pkg::S_SUB;
         gss_pkg::S_SUB: begin
            acc_in = sub_r;
            if (j_ff == nm1 || (j_ff + 1'b1 == i_ff && i_ff == nm1)) begin
               j_in     = i_ff;
               state_in = gss_pkg::S_DIV_GO;
            end else begin
               j_in     = (j_ff + 1'b1 == i_ff) ? j_ff + IW'(2) : j_ff + 1'b1;
               state_in = gss_pkg::S_MAC_RD;
            end
         end
         gss_pkg::S_DIV_GO: begin
            // diagonal read lands in a_rd_ff with j at i; move on only once j is at i so the divider sees it
            if (j_ff == i_ff && rd_col == i_ff) begin
               state_in = gss_pkg::S_DIV_WAIT;
            end
            j_in = i_ff;
         end
         gss_pkg::S_DIV_WAIT: begin
            if (!div_ctl.busy && !div_ctl.done && !conv_ff) begin
               div_start = 1'b1;
               conv_in   = 1'b1;
            end
            if (div_ctl.done) begin
               conv_in = 1'b0;
               if (i_ff == nm1) begin
                  i_in     = '0;
                  sweep_in = sweep_ff + 1'b1;
                  conv_in  = 1'b1;
                  state_in = gss_pkg::S_CHECK;
               end else begin
                  i_in     = i_ff + 1'b1;
                  j_in     = '0;
                  state_in = gss_pkg::S_ROW_RD;
               end
            end
         end
         gss_pkg::S_CHECK: begin
            if (adiff > 64'(tol_ff)) begin
               conv_in = 1'b0;
            end
            if (i_ff == nm1) begin
               i_in = '0;
               j_in = '0;
               if (conv_in) begin
                  stat_in  = gss_pkg::ST_CONVERGED;
                  state_in = gss_pkg::S_EMIT;
               end else if (sweep_ff >= lim_ff) begin
                  stat_in  = gss_pkg::ST_LIMIT;
                  state_in = gss_pkg::S_EMIT;
               end else begin
                  state_in = gss_pkg::S_ROW_RD;
               end
               conv_in = 1'b0;
            end else begin
               i_in = i_ff + 1'b1;
            end
         end
         gss_pkg::S_EMIT: begin
            if (i_ff == nm1) begin
               state_in = gss_pkg::S_IDLE;
            end else begin
               i_in = i_ff + 1'b1;
            end
         end
         default: state_in = gss_pkg::S_IDLE;
      endcase
   end

   gss_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (acc_ff),
      .divisor  (a_rd_ff),
      .ctl      (div_ctl),
      .quotient (div_q)
   );

   always_ff @(posedge clock) begin
      last_ff <= nm1;
      if (reset) begin
         state_ff <= gss_pkg::S_IDLE;
         i_ff     <= '0;
         j_ff     <= '0;
         sweep_ff <= '0;
         zd_ff    <= 1'b0;
         conv_ff  <= 1'b0;
         stat_ff  <= gss_pkg::ST_CONVERGED;
         size_ff  <= gss_pkg::SIZE_W'(16);
         tol_ff   <= gss_pkg::TOL_W'(1);
         lim_ff   <= gss_pkg::LIM_W'(1600);
         for (int k = 0; k < gss_pkg::MAX_SIZE; k++) begin
            prev_ff[k] <= '0;
            cur_ff[k]  <= '0;
         end
      end else begin
         state_ff <= state_in;
         i_ff     <= i_in;
         j_ff     <= j_in;
         sweep_ff <= sweep_in;
         zd_ff    <= zd_in;
         conv_ff  <= conv_in;
         stat_ff  <= stat_in;
         if (csr_write_enable) begin
            case (csr_index)
               gss_pkg::CSR_SIZE:  size_ff <= csr_data[gss_pkg::SIZE_W-1:0];
               gss_pkg::CSR_TOL:   tol_ff  <= csr_data;
               gss_pkg::CSR_LIMIT: lim_ff  <= csr_data[gss_pkg::LIM_W-1:0];
               default: ;
            endcase
         end
         // clear iterates at start
         if (state_ff == gss_pkg::S_IDLE && state_in == gss_pkg::S_DCHK_RD) begin
            for (int k = 0; k < gss_pkg::MAX_SIZE; k++) begin
               prev_ff[k] <= '0;
               cur_ff[k]  <= '0;
            end
         end
         if (state_ff == gss_pkg::S_DIV_WAIT && div_ctl.done) begin
            cur_ff[i_ff] <= div_q;
         end
         // advance previous iterate when another sweep follows
         if (state_ff == gss_pkg::S_CHECK && i_ff == nm1 &&
             state_in == gss_pkg::S_ROW_RD) begin
            for (int k = 0; k < gss_pkg::MAX_SIZE; k++) begin
               prev_ff[k] <= cur_ff[k];
            end
         end
      end
   end

   always_comb begin
      rsp_valid    = (state_ff == gss_pkg::S_EMIT);
      rsp_index    = i_ff;
      rsp_solution = zd_ff ? 32'sd0 : cur_ff[i_ff];
      rsp_status   = stat_ff;
      rsp_last     = (i_ff == last_ff);
   end
endmodule
`default_nettype wire
